// ===== rtl/dwo_pkg.sv =====
// Shared types, register indexes and CORDIC constants for the wheel odometry unit
package dwo_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_WRAP = 3'd0,
    CFG_DIST_PER_PULSE = 3'd1,
    CFG_YAW_PER_DIFF = 3'd2,
    CFG_START_X = 3'd3,
    CFG_START_Y = 3'd4,
    CFG_START_YAW = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD = 2'd1,
    DIR_BWD = 2'd2
  } dir_t;

  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_TRIG,
    ST_MUL2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul1_start;
    logic trig_start;
    logic mul2_start;
    logic pose_upd;
    logic out_load;
  } ctrl_t;

  localparam int unsigned DELTA_W = 18;
  localparam int unsigned SUM_W = 19;
  localparam int unsigned TRIG_W = 34;
  localparam int unsigned DIST_W = 34;
  localparam int unsigned ZW = 33;
  localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dwo_if.sv =====
// Valid/ready channel interfaces for samples and pose results
interface dwo_in_if;
  logic valid;
  logic ready;
  logic command;
  logic [15:0] left_pulse;
  logic [15:0] right_pulse;
  logic [1:0] direction;
  modport source (output valid, command, left_pulse, right_pulse, direction, input ready);
  modport sink (input valid, command, left_pulse, right_pulse, direction, output ready);
endinterface

interface dwo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

// ===== rtl/dwo_sermul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle
module dwo_sermul #(
  parameter int unsigned AW = 19,
  parameter int unsigned BW = 16,
  parameter bit B_SIGNED = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  output logic                 done,
  output logic [AW+BW:0]       prod
);

  localparam int unsigned CW = $clog2(BW);

  logic signed [AW:0]   acc_r, acc_nxt;
  logic [BW-1:0]        lo_r, lo_nxt;
  logic signed [AW-1:0] a_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic signed [AW+1:0] addend;
  logic signed [AW+1:0] sum;
  logic                 last;

  always_comb begin
    last = (cnt_r == CW'(BW - 1));
    if (!lo_r[0]) begin
      addend = '0;
    end else if (B_SIGNED && last) begin
      addend = -(AW+2)'(a_r);
    end else begin
      addend = (AW+2)'(a_r);
    end
    sum = (AW+2)'(acc_r) + addend;
    acc_nxt = acc_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      lo_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[AW+1:1];
      lo_nxt = {sum[0], lo_r[BW-1:1]};
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    lo_r <= lo_nxt;
    if (start) begin
      a_r <= a;
    end
  end

  assign done = done_r;
  assign prod = {acc_r, lo_r};

endmodule

// ===== rtl/dwo_cordic.sv =====
// Iterative CORDIC for cosine and sine of a binary angle, one rotation per cycle
module dwo_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [15:0]                        ang,
  output logic                               done,
  output logic signed [dwo_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [dwo_pkg::TRIG_W-1:0]  sin_o
);

  localparam int unsigned TW = dwo_pkg::TRIG_W;
  localparam int unsigned ZW = dwo_pkg::ZW;
  localparam int unsigned SW = $clog2(CORDIC_STEPS);

  logic signed [TW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SW-1:0]        i_r, i_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt, flip_r, flip_nxt;
  logic signed [TW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 flip;
  logic [31:0]          a0;

  always_comb begin
    flip = (ang[15:14] == 2'd1) || (ang[15:14] == 2'd2);
    a0 = {ang ^ {flip, 15'b0}, 16'b0};
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({1'b0, dwo_pkg::atan_lut(5'(i_r))});
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt = TW'(dwo_pkg::CORDIC_K);
      y_nxt = '0;
      z_nxt = $signed({a0[31], a0});
      i_nxt = '0;
      flip_nxt = flip;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + SW'(1);
      if (i_r == SW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r <= i_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign done = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

// ===== rtl/differential_wheel_odometry_unit.sv =====
// Top level of the differential wheel odometry unit
// Use: each transfer on in_chan carries a command, two wheel pulse counter
// readings and a drive direction. A pulse sample (command 0) moves the tracked
// pose; a restart (command 1) reloads the configured start pose and clears the
// stored readings and deltas. Every input transfer gives exactly one transfer
// on out_chan with pos_x, pos_y and heading after that step.
// Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// A restart goes from its transfer to ST_OUT and then into the output
// register. A pulse sample passes the serial distance and yaw multipliers,
// the CORDIC, and the serial position multipliers with the pose update at
// their end, then ST_OUT and the output register. One item is worked on at
// a time and the next transfer is taken in the cycle after the result is
// loaded; a pulse sample's time is set by the two serial multiplier passes
// and the CORDIC iterations. The result sits in an output register: a new
// item is taken while it waits, and that item's result holds back until the
// register is free. Reset (synchronous, active low) restores the register
// reset values, the zero pose and clears all stored readings and deltas.
module differential_wheel_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dwo_in_if.sink                            in_chan,
  dwo_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [dwo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwo_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned DW = dwo_pkg::DELTA_W;
  localparam int unsigned SW = dwo_pkg::SUM_W;
  localparam int unsigned TW = dwo_pkg::TRIG_W;
  localparam int unsigned LW = dwo_pkg::DIST_W;

  logic [16:0] pulse_wrap_r;
  logic [15:0] dpp_r, ypd_r, start_yaw_r;
  logic [31:0] start_x_r, start_y_r;

  logic [15:0]   prev_l_r, prev_r_r;
  logic [DW-1:0] pdl_r, pdr_r;
  logic [31:0]   x_acc_r, y_acc_r;
  logic [15:0]   yaw_acc_r;

  dwo_pkg::state_t state_r, state_nxt;
  dwo_pkg::ctrl_t  ctrl;

  logic              acc_in;
  logic [DW-1:0]     dl, dr;
  logic signed [SW-1:0] sum_lr, diff_lr;
  logic              mul_d_done, mul_y_done, trig_done, mul_x_done, mul_s_done;
  logic [SW+16:0]    prod_d, prod_y;
  logic signed [TW-1:0] cos_v, sin_v;
  logic [TW+LW:0]    prod_x, prod_s;
  logic [15:0]       dyaw, half, mid;
  logic signed [LW-1:0] travel;

  logic              out_valid_r;
  logic [31:0]       out_x_r, out_y_r;
  logic [15:0]       out_yaw_r;

  function automatic logic [DW-1:0] wheel_delta(
    input logic [15:0] cur, input logic [15:0] prv, input logic [DW-1:0] pdel,
    input logic [16:0] wrap, input logic [1:0] dir);
    logic [DW:0] raw;
    logic [DW-1:0] v;
    raw = {3'b0, cur} - {3'b0, prv} + ((cur < prv) ? {2'b0, wrap} : '0);
    if ((pdel == '0) && (prv == '0)) begin
      v = '0;
    end else if (dir == dwo_pkg::DIR_FWD) begin
      v = raw[DW-1:0];
    end else if (dir == dwo_pkg::DIR_BWD) begin
      v = -raw[DW-1:0];
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign acc_in = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == dwo_pkg::ST_IDLE);

  always_comb begin
    dl = wheel_delta(in_chan.left_pulse, prev_l_r, pdl_r, pulse_wrap_r, in_chan.direction);
    dr = wheel_delta(in_chan.right_pulse, prev_r_r, pdr_r, pulse_wrap_r, in_chan.direction);
    sum_lr = $signed({dl[DW-1], dl}) + $signed({dr[DW-1], dr});
    diff_lr = $signed({dr[DW-1], dr}) - $signed({dl[DW-1], dl});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dwo_pkg::ST_IDLE: begin
        if (acc_in) begin
          state_nxt = (in_chan.command == dwo_pkg::CMD_RESTART) ?
                      dwo_pkg::ST_OUT : dwo_pkg::ST_MUL1;
        end
      end
      dwo_pkg::ST_MUL1: if (mul_d_done) state_nxt = dwo_pkg::ST_TRIG;
      dwo_pkg::ST_TRIG: if (trig_done) state_nxt = dwo_pkg::ST_MUL2;
      dwo_pkg::ST_MUL2: if (mul_x_done) state_nxt = dwo_pkg::ST_OUT;
      dwo_pkg::ST_OUT: if (!out_valid_r || out_chan.ready) state_nxt = dwo_pkg::ST_IDLE;
      default: state_nxt = dwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      dwo_pkg::ST_IDLE: ctrl.mul1_start = acc_in && (in_chan.command != dwo_pkg::CMD_RESTART);
      dwo_pkg::ST_MUL1: ctrl.trig_start = mul_d_done;
      dwo_pkg::ST_TRIG: ctrl.mul2_start = trig_done;
      dwo_pkg::ST_MUL2: ctrl.pose_upd = mul_x_done;
      dwo_pkg::ST_OUT: ctrl.out_load = !out_valid_r || out_chan.ready;
      default: ctrl = '0;
    endcase
  end

  dwo_sermul #(.AW(SW), .BW(16), .B_SIGNED(1'b0)) u_mul_d (
    .clk(clk), .rst_n(rst_n), .start(ctrl.mul1_start), .a(sum_lr), .b(dpp_r),
    .done(mul_d_done), .prod(prod_d));

  dwo_sermul #(.AW(SW), .BW(16), .B_SIGNED(1'b0)) u_mul_y (
    .clk(clk), .rst_n(rst_n), .start(ctrl.mul1_start), .a(diff_lr), .b(ypd_r),
    .done(mul_y_done), .prod(prod_y));

  assign travel = $signed(prod_d[LW:1]);
  assign dyaw = prod_y[23:8];
  assign half = prod_y[24:9];
  assign mid = yaw_acc_r + half;

  dwo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(ctrl.trig_start), .ang(mid),
    .done(trig_done), .cos_o(cos_v), .sin_o(sin_v));

  dwo_sermul #(.AW(TW), .BW(LW), .B_SIGNED(1'b1)) u_mul_x (
    .clk(clk), .rst_n(rst_n), .start(ctrl.mul2_start), .a(cos_v), .b(travel),
    .done(mul_x_done), .prod(prod_x));

  dwo_sermul #(.AW(TW), .BW(LW), .B_SIGNED(1'b1)) u_mul_s (
    .clk(clk), .rst_n(rst_n), .start(ctrl.mul2_start), .a(sin_v), .b(travel),
    .done(mul_s_done), .prod(prod_s));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwo_pkg::ST_IDLE;
      pulse_wrap_r <= 17'd1024;
      dpp_r <= 16'd1311;
      ypd_r <= 16'd256;
      start_x_r <= '0;
      start_y_r <= '0;
      start_yaw_r <= '0;
      prev_l_r <= '0;
      prev_r_r <= '0;
      pdl_r <= '0;
      pdr_r <= '0;
      x_acc_r <= '0;
      y_acc_r <= '0;
      yaw_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dwo_pkg::CFG_PULSE_WRAP: pulse_wrap_r <= cfg_data[16:0];
          dwo_pkg::CFG_DIST_PER_PULSE: dpp_r <= cfg_data[15:0];
          dwo_pkg::CFG_YAW_PER_DIFF: ypd_r <= cfg_data[15:0];
          dwo_pkg::CFG_START_X: start_x_r <= cfg_data;
          dwo_pkg::CFG_START_Y: start_y_r <= cfg_data;
          dwo_pkg::CFG_START_YAW: start_yaw_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (acc_in) begin
        if (in_chan.command == dwo_pkg::CMD_RESTART) begin
          prev_l_r <= '0;
          prev_r_r <= '0;
          pdl_r <= '0;
          pdr_r <= '0;
          x_acc_r <= start_x_r;
          y_acc_r <= start_y_r;
          yaw_acc_r <= start_yaw_r;
        end else begin
          prev_l_r <= in_chan.left_pulse;
          prev_r_r <= in_chan.right_pulse;
          pdl_r <= dl;
          pdr_r <= dr;
        end
      end
      if (ctrl.pose_upd) begin
        x_acc_r <= x_acc_r + prod_x[61:30];
        y_acc_r <= y_acc_r + prod_s[61:30];
        yaw_acc_r <= yaw_acc_r + dyaw;
      end
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ctrl.out_load) begin
      out_x_r <= x_acc_r;
      out_y_r <= y_acc_r;
      out_yaw_r <= yaw_acc_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.pos_x = $signed(out_x_r);
  assign out_chan.pos_y = $signed(out_y_r);
  assign out_chan.heading = out_yaw_r;

`ifndef SYNTHESIS
  a_restart_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_chan.command == dwo_pkg::CMD_RESTART) |=> (state_r == dwo_pkg::ST_OUT))
    else $error("restart did not go straight to output");
  a_mul_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_d_done == mul_y_done) && (mul_x_done == mul_s_done))
    else $error("paired serial multipliers out of step");
  a_trig_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    trig_done |-> (state_r == dwo_pkg::ST_TRIG))
    else $error("CORDIC finished outside its state");
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dwo_pkg::ST_OUT))
    else $error("result raised without a load");
`endif

endmodule
